// File: rtl/core/hmti_pkg.sv
package hmti_pkg;

  // Item field widths
  localparam int POS_W    = 22;
  localparam int CORNER_W = 8;
  localparam int HEIGHT_W = 32;
  localparam int CELL_W   = 16;

  // binary32 packing
  localparam int MANT_W            = 23;
  localparam int NORM_W            = MANT_W + 1;
  localparam int EXP_W             = 8;
  localparam int FLOAT_BIAS        = 127;
  localparam int HEIGHT_SCALE_LOG2 = 11;
  localparam int LEAD_W            = $clog2(NORM_W);

  typedef struct packed {
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_z;
    logic [CORNER_W-1:0] corner_origin;
    logic [CORNER_W-1:0] corner_right;
    logic [CORNER_W-1:0] corner_far;
    logic [CORNER_W-1:0] corner_below;
  } in_item_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] height_bits;
    logic [CELL_W-1:0]   cell_index;
  } out_item_t;

endpackage

// File: rtl/core/heightmap_triangle_interpolator_top.sv
// Heightmap triangle interpolator.
//
// Input channel (in_valid / in_stall / in_item): one ground position in
// fixed point plus the four corner altitude bytes of its grid cell.
// Result channel (out_valid / out_stall / out_item): the binary32 pattern
// of the negated, scaled height and the cell's byte address row*side+col.
// An item moves when valid is high and stall is low at a rising edge.
//
// Three register stages: input register, interpolation register (V and the
// cell address, two narrow multiplies), output register (float packing).
// An accepted item passes the interpolation register, then the output
// register, before out_valid rises; one item per cycle is sustained
// while out_stall is low. Each stage has its own valid bit and loads
// whenever it is empty or its successor is moving, so bubbles close up
// while the receiver stalls and up to three items are held.
//
// Reset (rst_n low, synchronous) empties all stages; there is no other
// state. A stalled result holds in the output register unchanged.
module heightmap_triangle_interpolator_top
  import hmti_pkg::*;
#(
  parameter int GRID_SIDE     = 200,
  parameter int FRACTION_BITS = 14
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int VW = CORNER_W + FRACTION_BITS + 3; // signed working width
  localparam int VU = CORNER_W + FRACTION_BITS;     // V in [0, 255*Q]
  localparam logic [FRACTION_BITS:0] QV = {1'b1, {FRACTION_BITS{1'b0}}};

  // ---- stage handshake
  logic s0_valid_r, s1_valid_r, s2_valid_r;
  logic s0_load, s1_load, s2_load;

  assign s2_load  = !s2_valid_r || !out_stall;
  assign s1_load  = !s1_valid_r || s2_load;
  assign s0_load  = !s0_valid_r || s1_load;
  assign in_stall = !s0_load;

  // ---- stage 0: input register
  in_item_t s0_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (s0_load) begin
      s0_valid_r <= in_valid;
    end
    if (s0_load && in_valid) begin
      s0_item_r <= in_item;
    end
  end

  // ---- stage 1: triangle select and interpolation
  logic [FRACTION_BITS-1:0] u, w;
  logic [FRACTION_BITS:0]   uw_sum, fa, fb;
  logic                     upper;
  logic signed [VW-1:0]     s1_s, s2_s, s3_s, s4_s;
  logic signed [VW-1:0]     base_s, ca_s, cb_s, fa_s, fb_s, v_s;
  logic [VU-1:0]            v_nxt, v_r;
  logic [CELL_W-1:0]        row16, col16, cell_nxt, cell_r;

  assign u      = s0_item_r.pos_x[FRACTION_BITS-1:0];
  assign w      = s0_item_r.pos_z[FRACTION_BITS-1:0];
  assign uw_sum = {1'b0, u} + {1'b0, w};
  assign upper  = uw_sum[FRACTION_BITS];  // u+w >= Q, diagonal included

  assign s1_s = $signed({{(VW-CORNER_W){1'b0}}, s0_item_r.corner_origin});
  assign s2_s = $signed({{(VW-CORNER_W){1'b0}}, s0_item_r.corner_right});
  assign s3_s = $signed({{(VW-CORNER_W){1'b0}}, s0_item_r.corner_far});
  assign s4_s = $signed({{(VW-CORNER_W){1'b0}}, s0_item_r.corner_below});

  // pick the triangle first so only two multipliers are needed
  always_comb begin
    if (upper) begin
      base_s = s3_s;
      ca_s   = s4_s - s3_s;
      cb_s   = s2_s - s3_s;
      fa     = QV - {1'b0, u};
      fb     = QV - {1'b0, w};
    end else begin
      base_s = s1_s;
      ca_s   = s2_s - s1_s;
      cb_s   = s4_s - s1_s;
      fa     = {1'b0, u};
      fb     = {1'b0, w};
    end
  end

  assign fa_s  = $signed({{(VW-FRACTION_BITS-1){1'b0}}, fa});
  assign fb_s  = $signed({{(VW-FRACTION_BITS-1){1'b0}}, fb});
  assign v_s   = (base_s <<< FRACTION_BITS) + ca_s * fa_s + cb_s * fb_s;
  assign v_nxt = v_s[VW-1] ? '0 : v_s[VU-1:0];

  // address wraps to 16 bits, so only the low 16 bits of row matter
  assign row16    = CELL_W'(s0_item_r.pos_z >> FRACTION_BITS);
  assign col16    = CELL_W'(s0_item_r.pos_x >> FRACTION_BITS);
  assign cell_nxt = row16 * CELL_W'(GRID_SIDE) + col16;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= s0_valid_r;
    end
    if (s1_load && s0_valid_r) begin
      v_r    <= v_nxt;
      cell_r <= cell_nxt;
    end
  end

  // ---- stage 2: float packing and output register
  logic [HEIGHT_W-1:0] height_nxt;
  out_item_t           out_item_r;

  hmti_pack #(
    .FRACTION_BITS (FRACTION_BITS),
    .V_W           (VU)
  ) u_pack (
    .v           (v_r),
    .height_bits (height_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_load) begin
      s2_valid_r <= s1_valid_r;
    end
    if (s2_load && s1_valid_r) begin
      out_item_r.height_bits <= height_nxt;
      out_item_r.cell_index  <= cell_r;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: rtl/core/hmti_pack.sv
module hmti_pack
  import hmti_pkg::*;
#(
  parameter int FRACTION_BITS = 14,
  parameter int V_W           = CORNER_W + FRACTION_BITS
) (
  input  logic [V_W-1:0]      v,
  output logic [HEIGHT_W-1:0] height_bits
);

  // exponent of the least significant bit of V, after the 2^11/Q scale
  localparam int EXP_OFFSET = FLOAT_BIAS + HEIGHT_SCALE_LOG2 - FRACTION_BITS;

  logic [NORM_W-1:0] ext;
  logic [NORM_W-1:0] norm;
  logic [LEAD_W-1:0] lead;
  logic [EXP_W-1:0]  expo;

  assign ext = NORM_W'(v);

  // leading-one position
  always_comb begin
    lead = '0;
    for (int i = 0; i < NORM_W; i++) begin
      if (ext[i]) begin
        lead = LEAD_W'(i);
      end
    end
  end

  assign norm = ext << (LEAD_W'(MANT_W) - lead);
  assign expo = EXP_W'(EXP_OFFSET) + EXP_W'(lead);

  // negative sign always; zero gives +0
  assign height_bits = (ext == '0) ? '0 : {1'b1, expo, norm[MANT_W-1:0]};

endmodule
